### rtl/core/pnm_binary_stream_decoder_core_assert.svh
// Assertion macros used by the PNM decoder RTL.
// No dependencies; included by the decoder core, which checks its own logic.
`ifndef PNM_BINARY_STREAM_DECODER_CORE_ASSERT_SVH
`define PNM_BINARY_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
`define PNM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PNM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define PNM_ASSERT(label, clk, rst_n, prop, msg)
`define PNM_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/core/pnm_pkg.sv
// Types and constants of the PNM stream decoder.
// No dependencies.
package pnm_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic        is_header;
    logic [1:0]  image_kind;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [15:0] max_value;
    logic [7:0]  sample_value;
    logic [1:0]  channel;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  error_code;
    logic        image_done;
    logic        last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_KIND, PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_DATA, PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PARSE, ST_DIV, ST_BITS, ST_OUT
  } state_e;

  localparam logic [1:0] ErrOk = 2'd0;
  localparam logic [1:0] ErrMagic = 2'd1;
  localparam logic [1:0] ErrMax = 2'd2;
  localparam logic [1:0] ErrSize = 2'd3;

  localparam logic [1:0] KindBitmap = 2'd0;
  localparam logic [1:0] KindColor = 2'd2;

  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChFour = 8'h34;
  localparam logic [7:0] ChSix = 8'h36;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;

endpackage

### rtl/core/pnm_divider.sv
// Bit-serial restoring divider for the sample scale v*255/max.
// Depends on nothing; one quotient bit per cycle, quotient saturated to 255.
module pnm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [7:0]  sample_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [7:0]  quot_o
);

  logic [15:0] rem_q, rem_d;
  logic [15:0] num_q, num_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] div_q, div_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, num_q[15]};
    if (start_i) begin
      rem_d  = '0;
      num_d  = {sample_i, 8'h00} - {8'h00, sample_i};
      quo_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 5'd16;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = 16'(trial - {1'b0, div_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      num_d = {num_q[14:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd1);
  assign quot_o = (quo_d[15:8] != 8'h00) ? 8'hff : quo_d[7:0];

endmodule

### rtl/core/pnm_binary_stream_decoder_core.sv
// Top level of the binary PNM stream decoder.
// Depends on pnm_pkg, pnm_divider and pnm_binary_stream_decoder_core_assert.svh.
//
//  channel  direction  handshake            payload
//  input    in         in_valid_i/in_ready_o  in_data_i   (pnm_pkg::in_t)
//  output   out        out_valid_o/out_ready_i out_data_o (pnm_pkg::out_t)
//
// A header byte goes from idle to the parse state, then to the output state if it
// completes a header result. A gray or color sample passes the parse state, the
// bit-serial divider and output state; a bitmap byte, the parse and bit states.
// A result waits in the output register until it is taken. A new request is held
// off while a result waits, and a stalled output also holds bitmap pixels.
// Reset clears all parse state; no clearing pass is needed.
`include "pnm_binary_stream_decoder_core_assert.svh"
module pnm_binary_stream_decoder_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pnm_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pnm_pkg::out_t  out_data_o
);

  localparam int unsigned DimLimit = (MAX_DIM < 4096) ? MAX_DIM : 4096;

  pnm_pkg::state_e state_q, state_d;
  pnm_pkg::phase_e phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic [15:0] maxv_q, maxv_d;
  logic [15:0] acc_q, acc_d;
  logic [11:0] col_q, col_d;
  logic [11:0] row_q, row_d;
  logic [1:0]  chan_q, chan_d;
  logic        cmt_q, cmt_d;
  logic        dig_q, dig_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  bit_q, bit_d;
  logic        ov_q, ov_d;
  pnm_pkg::out_t out_q, out_d;

  logic        div_start;
  logic        div_done;
  logic [7:0]  div_quot;

  pnm_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sample_i  (byte_q),
    .divisor_i (maxv_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  logic        accept;
  logic [7:0]  b;
  logic        is_digit;
  logic [19:0] acc_mul;
  logic [1:0]  dim_err;
  logic [12:0] col_nx;
  logic [12:0] row_nx;
  logic        wrap;
  logic        fin;
  logic [12:0] left;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == pnm_pkg::ST_IDLE) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  assign b = byte_q;
  assign is_digit = (b >= pnm_pkg::ChZero) && (b <= pnm_pkg::ChNine);
  assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + {12'h000, 8'(b - pnm_pkg::ChZero)};
  assign dim_err = (acc_q == 16'd0) ? pnm_pkg::ErrMagic :
                   (acc_q > 16'(DimLimit)) ? pnm_pkg::ErrSize : pnm_pkg::ErrOk;
  assign col_nx = {1'b0, col_q} + 13'd1;
  assign row_nx = {1'b0, row_q} + 13'd1;
  assign wrap = (col_nx >= width_q);
  assign fin = wrap && (row_nx >= height_q);
  assign left = width_q - {1'b0, col_q};

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    kind_d   = kind_q;
    width_d  = width_q;
    height_d = height_q;
    maxv_d   = maxv_q;
    acc_d    = acc_q;
    col_d    = col_q;
    row_d    = row_q;
    chan_d   = chan_q;
    cmt_d    = cmt_q;
    dig_d    = dig_q;
    byte_d   = byte_q;
    bit_d    = bit_q;
    ov_d     = ov_q;
    out_d    = out_q;
    div_start = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      pnm_pkg::ST_IDLE: begin
        if (accept) begin
          byte_d = in_data_i.byte_value;
          state_d = pnm_pkg::ST_PARSE;
          if (in_data_i.frame_start) begin
            phase_d = pnm_pkg::PH_MAGIC;
            kind_d = '0; width_d = '0; height_d = '0; maxv_d = '0; acc_d = '0;
            col_d = '0; row_d = '0; chan_d = '0; cmt_d = 1'b0; dig_d = 1'b0;
          end
        end
      end
      pnm_pkg::ST_PARSE: begin
        out_d = '0;
        out_d.is_header = 1'b1;
        out_d.image_kind = kind_q;
        out_d.image_width = width_q;
        out_d.image_height = height_q;
        out_d.max_value = maxv_q;
        out_d.last_of_run = 1'b1;
        state_d = pnm_pkg::ST_IDLE;
        case (phase_q)
          pnm_pkg::PH_MAGIC: begin
            if (b != pnm_pkg::ChP) begin
              out_d.error_code = pnm_pkg::ErrMagic;
              phase_d = pnm_pkg::PH_HALT;
              state_d = pnm_pkg::ST_OUT;
            end else begin
              phase_d = pnm_pkg::PH_KIND;
            end
          end
          pnm_pkg::PH_KIND: begin
            if (b < pnm_pkg::ChFour || b > pnm_pkg::ChSix) begin
              out_d.error_code = pnm_pkg::ErrMagic;
              phase_d = pnm_pkg::PH_HALT;
              state_d = pnm_pkg::ST_OUT;
            end else begin
              kind_d = 2'(b - pnm_pkg::ChFour);
              phase_d = pnm_pkg::PH_WIDTH;
            end
          end
          pnm_pkg::PH_WIDTH, pnm_pkg::PH_HEIGHT, pnm_pkg::PH_MAXV: begin
            if (cmt_q) begin
              if (b == pnm_pkg::ChLf || b == pnm_pkg::ChCr) begin
                cmt_d = 1'b0;
              end
            end else if (is_digit) begin
              acc_d = (acc_mul > 20'd65535) ? 16'hffff : acc_mul[15:0];
              dig_d = 1'b1;
            end else if (dig_q) begin
              acc_d = '0;
              dig_d = 1'b0;
              col_d = '0; row_d = '0; chan_d = '0;
              if (phase_q == pnm_pkg::PH_WIDTH) begin
                width_d = (acc_q > 16'd8191) ? 13'h1fff : acc_q[12:0];
                out_d.image_width = width_d;
                if (dim_err != pnm_pkg::ErrOk) begin
                  out_d.error_code = dim_err;
                  phase_d = pnm_pkg::PH_HALT;
                  state_d = pnm_pkg::ST_OUT;
                end else begin
                  phase_d = pnm_pkg::PH_HEIGHT;
                  cmt_d = (b == pnm_pkg::ChHash);
                end
              end else if (phase_q == pnm_pkg::PH_HEIGHT) begin
                height_d = (acc_q > 16'd8191) ? 13'h1fff : acc_q[12:0];
                out_d.image_height = height_d;
                if (dim_err != pnm_pkg::ErrOk || kind_q == pnm_pkg::KindBitmap) begin
                  out_d.error_code = dim_err;
                  phase_d = (dim_err != pnm_pkg::ErrOk) ? pnm_pkg::PH_HALT
                                                         : pnm_pkg::PH_DATA;
                  state_d = pnm_pkg::ST_OUT;
                end else begin
                  phase_d = pnm_pkg::PH_MAXV;
                  cmt_d = (b == pnm_pkg::ChHash);
                end
              end else begin
                maxv_d = acc_q;
                out_d.max_value = acc_q;
                out_d.error_code = (acc_q == 16'd0) ? pnm_pkg::ErrMax : pnm_pkg::ErrOk;
                phase_d = (acc_q == 16'd0) ? pnm_pkg::PH_HALT : pnm_pkg::PH_DATA;
                state_d = pnm_pkg::ST_OUT;
              end
            end else if (b == pnm_pkg::ChHash) begin
              cmt_d = 1'b1;
            end
          end
          pnm_pkg::PH_DATA: begin
            if (kind_q == pnm_pkg::KindBitmap) begin
              bit_d = (left > 13'd8) ? 4'd8 : left[3:0];
              state_d = pnm_pkg::ST_BITS;
            end else begin
              div_start = 1'b1;
              state_d = pnm_pkg::ST_DIV;
            end
          end
          default: ;
        endcase
      end
      pnm_pkg::ST_DIV: begin
        if (div_done) begin
          out_d = '0;
          out_d.image_kind = kind_q;
          out_d.sample_value = div_quot;
          out_d.channel = chan_q;
          out_d.col = col_q;
          out_d.row = row_q;
          out_d.last_of_run = 1'b1;
          if (kind_q == pnm_pkg::KindColor && chan_q < 2'd2) begin
            chan_d = chan_q + 2'd1;
          end else begin
            chan_d = '0;
            col_d = wrap ? 12'd0 : col_nx[11:0];
            row_d = wrap ? row_nx[11:0] : row_q;
            out_d.image_done = fin;
            if (fin) begin
              phase_d = pnm_pkg::PH_HALT;
            end
          end
          state_d = pnm_pkg::ST_OUT;
        end
      end
      pnm_pkg::ST_BITS: begin
        if (!ov_q || out_ready_i) begin
          out_d = '0;
          out_d.image_kind = kind_q;
          out_d.sample_value = byte_q[7] ? 8'hff : 8'h00;
          out_d.col = col_q;
          out_d.row = row_q;
          out_d.image_done = fin;
          out_d.last_of_run = (bit_q == 4'd1);
          ov_d = 1'b1;
          byte_d = {byte_q[6:0], 1'b0};
          bit_d = bit_q - 4'd1;
          col_d = wrap ? 12'd0 : col_nx[11:0];
          row_d = wrap ? row_nx[11:0] : row_q;
          if (fin) begin
            phase_d = pnm_pkg::PH_HALT;
          end
          if (bit_q == 4'd1) begin
            state_d = pnm_pkg::ST_IDLE;
          end
        end
      end
      pnm_pkg::ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          state_d = pnm_pkg::ST_IDLE;
        end
      end
      default: state_d = pnm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pnm_pkg::ST_IDLE;
      phase_q  <= pnm_pkg::PH_MAGIC;
      kind_q   <= '0;
      width_q  <= '0;
      height_q <= '0;
      maxv_q   <= '0;
      acc_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      chan_q   <= '0;
      cmt_q    <= 1'b0;
      dig_q    <= 1'b0;
      bit_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      width_q  <= width_d;
      height_q <= height_d;
      maxv_q   <= maxv_d;
      acc_q    <= acc_d;
      col_q    <= col_d;
      row_q    <= row_d;
      chan_q   <= chan_d;
      cmt_q    <= cmt_d;
      dig_q    <= dig_d;
      bit_q    <= bit_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  `PNM_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == pnm_pkg::ST_IDLE, "ready outside idle")
  `PNM_ASSERT_IMPL(a_hdr_last, clk_i, rst_ni, out_valid_o && out_data_o.is_header, out_data_o.last_of_run, "header not last of run")
  `PNM_ASSERT_IMPL(a_done_last, clk_i, rst_ni, out_valid_o && out_data_o.image_done, out_data_o.last_of_run, "image done not last")
  `PNM_ASSERT_IMPL(a_bits_cnt, clk_i, rst_ni, state_q == pnm_pkg::ST_BITS, bit_q != 4'd0, "bitmap count empty")

endmodule

### test/pnm_binary_stream_decoder_core_tb.sv
// Self-checking testbench of the binary PNM stream decoder core.
// Depends on pnm_pkg and the pnm_binary_stream_decoder_core RTL; it feeds directed
// and random PNM files byte by byte and checks each result against its own decoder.
module pnm_binary_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxDim = 4096;
  localparam int unsigned DimLimit = (MaxDim < 4096) ? MaxDim : 4096;

  class pnm_decode_model;
    pnm_pkg::phase_e phase;
    logic [1:0]  kind;
    int unsigned wid, hgt, maxv, accum, col, rowc, chan;
    bit          in_cmt, digits;
    pnm_pkg::out_t expected_q[$];
    int          mismatches;

    function void clear();
      phase = pnm_pkg::PH_MAGIC;
      kind = pnm_pkg::KindBitmap;
      wid = 0; hgt = 0; maxv = 0; accum = 0;
      col = 0; rowc = 0; chan = 0;
      in_cmt = 0; digits = 0;
    endfunction

    function void push_header(logic [1:0] err);
      pnm_pkg::out_t o;
      o = '0;
      o.is_header = 1'b1;
      o.image_kind = kind;
      o.image_width = wid[12:0];
      o.image_height = hgt[12:0];
      o.max_value = maxv[15:0];
      o.error_code = err;
      o.last_of_run = 1'b1;
      expected_q.push_back(o);
      phase = (err != pnm_pkg::ErrOk) ? pnm_pkg::PH_HALT : pnm_pkg::PH_DATA;
      col = 0; rowc = 0; chan = 0;
    endfunction

    function logic [1:0] dim_err(int unsigned v);
      if (v == 0) return pnm_pkg::ErrMagic;
      if (v > DimLimit) return pnm_pkg::ErrSize;
      return pnm_pkg::ErrOk;
    endfunction

    function bit step_pixel();
      col++;
      if (col >= wid) begin
        col = 0;
        rowc++;
        if (rowc >= hgt) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void number_char(logic [7:0] b);
      int unsigned v;
      logic [1:0]  err;
      if (in_cmt) begin
        if (b == pnm_pkg::ChLf || b == pnm_pkg::ChCr) in_cmt = 0;
        return;
      end
      if (b >= pnm_pkg::ChZero && b <= pnm_pkg::ChNine) begin
        accum = accum * 10 + (b - pnm_pkg::ChZero);
        if (accum > 65535) accum = 65535;
        digits = 1;
        return;
      end
      if (!digits) begin
        if (b == pnm_pkg::ChHash) in_cmt = 1;
        return;
      end
      v = accum;
      accum = 0;
      digits = 0;
      if (phase == pnm_pkg::PH_WIDTH) begin
        wid = (v > 8191) ? 8191 : v;
        err = dim_err(v);
        if (err != pnm_pkg::ErrOk) begin
          push_header(err);
          return;
        end
        phase = pnm_pkg::PH_HEIGHT;
      end else if (phase == pnm_pkg::PH_HEIGHT) begin
        hgt = (v > 8191) ? 8191 : v;
        err = dim_err(v);
        if (err != pnm_pkg::ErrOk || kind == pnm_pkg::KindBitmap) begin
          push_header(err);
          return;
        end
        phase = pnm_pkg::PH_MAXV;
      end else begin
        maxv = v;
        push_header((v == 0) ? pnm_pkg::ErrMax : pnm_pkg::ErrOk);
        return;
      end
      if (b == pnm_pkg::ChHash) in_cmt = 1;
    endfunction

    function void data_char(logic [7:0] b);
      pnm_pkg::out_t o;
      int unsigned cnt, s;
      bit          done;
      o = '0;
      o.image_kind = kind;
      done = 0;
      if (kind == pnm_pkg::KindBitmap) begin
        cnt = (wid - col > 8) ? 8 : wid - col;
        for (int unsigned i = 0; i < cnt; i++) begin
          o.sample_value = b[7 - i] ? 8'd255 : 8'd0;
          o.col = col[11:0];
          o.row = rowc[11:0];
          done = step_pixel();
          o.image_done = done;
          o.last_of_run = (i + 1 == cnt);
          expected_q.push_back(o);
        end
      end else begin
        s = (b * 255) / maxv;
        o.sample_value = (s > 255) ? 8'd255 : s[7:0];
        o.channel = chan[1:0];
        o.col = col[11:0];
        o.row = rowc[11:0];
        if (kind == pnm_pkg::KindColor && chan < 2) begin
          chan++;
        end else begin
          chan = 0;
          done = step_pixel();
        end
        o.image_done = done;
        o.last_of_run = 1'b1;
        expected_q.push_back(o);
      end
      if (done) phase = pnm_pkg::PH_HALT;
    endfunction

    function void note_request(pnm_pkg::in_t r);
      logic [7:0] b;
      b = r.byte_value;
      if (r.frame_start) clear();
      case (phase)
        pnm_pkg::PH_MAGIC: begin
          if (b != pnm_pkg::ChP) push_header(pnm_pkg::ErrMagic);
          else phase = pnm_pkg::PH_KIND;
        end
        pnm_pkg::PH_KIND: begin
          if (b < pnm_pkg::ChFour || b > pnm_pkg::ChSix) begin
            push_header(pnm_pkg::ErrMagic);
          end else begin
            kind = 2'(b - pnm_pkg::ChFour);
            phase = pnm_pkg::PH_WIDTH;
          end
        end
        pnm_pkg::PH_WIDTH, pnm_pkg::PH_HEIGHT, pnm_pkg::PH_MAXV: number_char(b);
        pnm_pkg::PH_DATA: data_char(b);
        default: ;
      endcase
    endfunction

    function void check_result(pnm_pkg::out_t got);
      pnm_pkg::out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic  clk, rst_n;
  logic  in_valid, in_ready, out_valid, out_ready;
  pnm_pkg::in_t  in_data;
  pnm_pkg::out_t out_data;
  bit    quiet;
  int    stall;
  pnm_decode_model decoder;

  pnm_binary_stream_decoder_core #(.MAX_DIM(MaxDim)) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 4) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) decoder.check_result(out_data);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit fs);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{byte_value: b, frame_start: fs};
    do @(posedge clk); while (!in_ready);
    decoder.note_request(in_data);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit fs);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fs && i == 0);
  endtask

  function automatic string separator();
    case ($urandom_range(0, 5))
      0: return "\n";
      1: return "\t ";
      2: return "#z\r";
      3: return " #note\n";
      default: return " ";
    endcase
  endfunction

  task automatic send_random_file(output int sent);
    int unsigned k, w, h, m, n;
    string       head;
    k = $urandom_range(0, 2);
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 13) : $urandom_range(1, 5);
    h = $urandom_range(1, 3);
    case ($urandom_range(0, 4))
      0: m = 255;
      1: m = 1;
      2: m = $urandom_range(2, 300);
      3: m = 1000;
      default: m = $urandom_range(10, 200);
    endcase
    head = $sformatf("P%0d%s%0d%s%0d", k + 4, separator(), w, separator(), h);
    if (k != 0) head = {head, separator(), $sformatf("%0d", m)};
    head = {head, ($urandom_range(0, 1) ? "\n" : " ")};
    n = (k == 0) ? ((w + 7) / 8) * h : (k == 1) ? w * h : 3 * w * h;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
    send_text(head, 1'b1);
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    sent = head.len() + n;
    if ($urandom_range(0, 5) == 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      sent++;
    end
  endtask

  initial begin
    int total, got;
    decoder = new();
    decoder.clear();
    decoder.mismatches = 0;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_text("Q", 1'b1);
    send_text("P3", 1'b1);
    send_text("P4#x\n9 1 ", 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("P5 0 ", 1'b1);
    send_text("P6 1 5000 ", 1'b1);
    send_text("P5 1#c\n1 0 ", 1'b1);
    send_text("P5 2 1 9\n", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_text("P6 1 1 99999 ", 1'b1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);

    total = 0;
    while (total < 110) begin
      if (total > 80) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        total++;
      end else begin
        send_random_file(got);
        total += got;
      end
    end
    in_valid = 1'b0;

    while (decoder.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (decoder.mismatches == 0 && decoder.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule
